@@ design/time_series_similarity_defines.svh @@
// Assertion macros used by the time_series_similarity controller (tss_ctrl).
// Expects signals named clk and rst_n in the including module.
`ifndef TIME_SERIES_SIMILARITY_DEFINES_SVH
`define TIME_SERIES_SIMILARITY_DEFINES_SVH

// same-cycle implication
`define TSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tss_pkg.sv @@
// Package for time_series_similarity: widths, mode codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int MAX_SERIES_LENGTH = 4096;
  localparam int CNT_W             = $clog2(MAX_SERIES_LENGTH + 1);
  localparam int PROD_W            = 2 * SAMPLE_W - 1;
  localparam int SUM_W             = 48;
  localparam int NUM_W             = PROD_W + CNT_W;
  localparam int DIV_W             = CNT_W + 1;
  localparam int STEP_W            = $clog2(NUM_W + 1);
  localparam int RES_W             = NUM_W + 2;
  localparam int SIM_W             = 32;
  localparam int FRAC_W            = 24;
  localparam int MODE_W            = 3;
  localparam int IN_DATA_W         = 2 * SAMPLE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_POS_RECT = 3'd0,
    MODE_MEAN_P1  = 3'd1,
    MODE_CLAMP    = 3'd2,
    MODE_ABS      = 3'd3,
    MODE_NEG_PART = 3'd4,
    MODE_GAUSS    = 3'd5,
    MODE_MEAN     = 3'd6,
    MODE_NEG_RECT = 3'd7
  } mode_t;

  localparam mode_t MODE_RESET = MODE_MEAN;

  typedef struct packed {
    logic take;
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ design/tss_ctrl.sv @@
// Controller for time_series_similarity: sequences accumulate, divide and
// result hand-off. Depends on tss_pkg and time_series_similarity_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "time_series_similarity_defines.svh"

module tss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_tlast,
  output logic                 in_tready,
  input  wire logic            out_tready,
  output logic                 out_tvalid,
  output tss_pkg::dp_cmd_t     cmd,
  input  wire tss_pkg::dp_sts_t sts
);
  import tss_pkg::*;

  typedef enum logic [2:0] {
    S_ACC,
    S_DRAIN,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    in_tready  = (state_r == S_ACC);
    cmd.take   = in_tvalid && in_tready;
    cmd.load   = (state_r == S_LOAD);
    cmd.step   = (state_r == S_DIV);
    cmd.finish = (state_r == S_DONE) && (!out_valid_r || out_tready);
    out_tvalid = out_valid_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_ACC: begin
        if (cmd.take && in_tlast) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.finish) state_nxt = S_ACC;
      end
      default: state_nxt = S_ACC;
    endcase
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TSS_ASSERT_NXT(a_last_stalls, cmd.take && in_tlast, !in_tready, "input open after last")
  `TSS_ASSERT_IMP(a_finish_free, cmd.finish, !out_valid_r || out_tready, "result overwritten")
  `TSS_ASSERT_NXT(a_finish_valid, cmd.finish, out_valid_r && in_tready, "result not posted")
  `TSS_ASSERT_NXT(a_div_exit, cmd.step && sts.div_done, state_r == S_DONE, "divide exit lost")

endmodule

`default_nettype wire

@@ design/tss_dp.sv @@
// Datapath for time_series_similarity: multiplier, product sums, pair count,
// bit-serial divider, mode transform and result register. Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tss_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tss_pkg::MODE_W-1:0]    cfg_wdata,
  input  wire logic [tss_pkg::SAMPLE_W-1:0]  in_a,
  input  wire logic [tss_pkg::SAMPLE_W-1:0]  in_b,
  input  wire tss_pkg::dp_cmd_t              cmd,
  output tss_pkg::dp_sts_t                   sts,
  output logic [tss_pkg::SIM_W-1:0]          res_sim,
  output logic                               res_flag
);
  import tss_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SERIES_LENGTH);
  localparam logic signed [RES_W-1:0] ONE_Q = RES_W'(64'd1 << FRAC_W);
  localparam logic signed [RES_W-1:0] SAT_HI =
    {{(RES_W-SIM_W+1){1'b0}}, {(SIM_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_LO =
    {{(RES_W-SIM_W+1){1'b1}}, {(SIM_W-1){1'b0}}};

  mode_t               mode_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                pv_r;
  logic                sgn_r;
  logic [PROD_W-1:0]   mag_r;
  logic [SUM_W-1:0]    psum_r, psum_nxt;
  logic [SUM_W-1:0]    asum_r, asum_nxt;
  logic [NUM_W-1:0]    quo_r;
  logic [DIV_W-1:0]    rem_r;
  logic [DIV_W-1:0]    dvs_r;
  logic [STEP_W-1:0]   step_r;
  logic                neg_r;
  logic                czero_r;
  logic [SIM_W-1:0]    sim_r;
  logic                flag_r;

  logic [SAMPLE_W:0]     a_mag, b_mag;
  logic [PROD_W-1:0]     mag_full;
  logic [SUM_W-1:0]      mag_ext, psum_mag, num_full;
  logic [DIV_W:0]        rem_sh, rem_sub;
  logic                  ge;
  logic signed [RES_W-1:0] q_ext, mean, z;
  logic [SIM_W-1:0]      sat;

  always_comb begin
    a_mag    = in_a[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {in_a[SAMPLE_W-1], in_a})
                                : {1'b0, in_a};
    b_mag    = in_b[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {in_b[SAMPLE_W-1], in_b})
                                : {1'b0, in_b};
    mag_full = PROD_W'(a_mag) * PROD_W'(b_mag);

    mag_ext  = {{(SUM_W-PROD_W){1'b0}}, mag_r};
    psum_nxt = sgn_r ? (psum_r - mag_ext) : (psum_r + mag_ext);
    asum_nxt = asum_r + mag_ext;

    psum_mag = psum_r[SUM_W-1] ? (SUM_W'(0) - psum_r) : psum_r;
    case (mode_r)
      MODE_POS_RECT: num_full = psum_r + asum_r;
      MODE_NEG_RECT: num_full = asum_r - psum_r;
      default:       num_full = psum_mag;
    endcase

    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});

    q_ext = signed'({2'b00, quo_r});
    mean  = neg_r ? -q_ext : q_ext;
    case (mode_r) inside
      MODE_MEAN_P1:                       z = mean + ONE_Q;
      MODE_CLAMP:                         z = neg_r ? RES_W'(0) : q_ext;
      MODE_ABS, MODE_POS_RECT, MODE_NEG_RECT: z = q_ext;
      MODE_NEG_PART:                      z = neg_r ? q_ext : RES_W'(0);
      MODE_MEAN:                          z = mean;
      default:                            z = RES_W'(0);
    endcase
    if (czero_r) z = RES_W'(0);
    if (z > SAT_HI) begin
      sat = SAT_HI[SIM_W-1:0];
    end else if (z < SAT_LO) begin
      sat = SAT_LO[SIM_W-1:0];
    end else begin
      sat = z[SIM_W-1:0];
    end

    sts.div_done = cmd.step && (step_r == STEP_W'(1));
    res_sim      = sim_r;
    res_flag     = flag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      cnt_r  <= '0;
      pv_r   <= 1'b0;
      psum_r <= '0;
      asum_r <= '0;
    end else begin
      if (cfg_we) mode_r <= mode_t'(cfg_wdata);
      pv_r <= 1'b0;
      if (cmd.take && (cnt_r < MAX_CNT)) begin
        cnt_r <= cnt_r + CNT_W'(1);
        pv_r  <= 1'b1;
      end
      if (pv_r) begin
        psum_r <= psum_nxt;
        asum_r <= asum_nxt;
      end
      if (cmd.finish) begin
        cnt_r  <= '0;
        psum_r <= '0;
        asum_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mag_r <= mag_full;
      sgn_r <= in_a[SAMPLE_W-1] ^ in_b[SAMPLE_W-1];
    end
    if (cmd.load) begin
      quo_r   <= num_full[NUM_W-1:0];
      rem_r   <= '0;
      dvs_r   <= ((mode_r == MODE_POS_RECT) || (mode_r == MODE_NEG_RECT)) ?
                 {cnt_r, 1'b0} : {1'b0, cnt_r};
      step_r  <= STEP_W'(NUM_W);
      neg_r   <= psum_r[SUM_W-1];
      czero_r <= (cnt_r == '0);
    end else if (cmd.step) begin
      rem_r  <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_r  <= {quo_r[NUM_W-2:0], ge};
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.finish) begin
      sim_r  <= sat;
      flag_r <= (mode_r == MODE_GAUSS);
    end
  end

endmodule

`default_nettype wire

@@ design/time_series_similarity.sv @@
// Usage: stream paired Q3.12 samples in on the in_ channel, one pair per
// transfer; in_tlast marks the last pair of a series.
// Each pair within a series is taken in one cycle; the block accumulates the
// signed and absolute product sums and counts pairs (up to 4096 per series).
// After the last pair in_tready drops while a bit-serial divider runs, one
// quotient bit per cycle over 44 bits; the controller steps through the drain,
// load, divide and done states before the Q7.24 result appears on out_tvalid.
// The result sits in an output register: the next series streams in while it
// waits; after that series' last pair the block holds with in_tready low
// until out_tready takes the waiting result.
// out_tuser is set when mode 5 (unsupported) is selected; the result is then 0.
// cfg_we writes similarity_mode from cfg_wdata; write it only while idle.
// Reset (rst_n low, synchronous) clears the sums and count, drops out_tvalid
// and sets similarity_mode to 6 (plain mean).
// Depends on tss_pkg, tss_ctrl and tss_dp.
`timescale 1ns / 1ps
`default_nettype none

module time_series_similarity (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tss_pkg::MODE_W-1:0]    cfg_wdata,     // similarity_mode
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tss_pkg::IN_DATA_W-1:0] in_tdata,      // sample_a, sample_b
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [tss_pkg::SIM_W-1:0]          out_tdata,     // similarity
  output logic                               out_tuser      // mode_unsupported
);
  import tss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  tss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_a      (in_tdata[SAMPLE_W-1:0]),
    .in_b      (in_tdata[IN_DATA_W-1:SAMPLE_W]),
    .cmd       (cmd),
    .sts       (sts),
    .res_sim   (out_tdata),
    .res_flag  (out_tuser)
  );

endmodule

`default_nettype wire
